@@ src/wcuf_pkg.sv @@
// ----------------------------------------------------------------------------
// wcuf_pkg
// Shared types and codes for the union-find engine.
// ----------------------------------------------------------------------------
package wcuf_pkg;

  localparam int LABEL_W = 10;

  // operation codes
  localparam logic OP_UNION = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  // source of the pending result
  localparam logic [1:0] PEND_A     = 2'd0;  // node_a itself, out of range
  localparam logic [1:0] PEND_CUR   = 2'd1;  // root reached by the walk
  localparam logic [1:0] PEND_MERGE = 2'd2;  // smaller of two distinct roots

  typedef logic [LABEL_W-1:0] label_t;

  typedef struct packed {
    logic       load;      // item accepted, start walk at node_a
    logic       start_b;   // start walk at node_b
    logic       step;      // follow parent link
    logic       link_we;   // point larger root at smaller root
    logic       clear_we;  // init sweep write
    logic       pend_set;
    logic [1:0] pend_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_a_oor;   // input node_a has no store entry
    logic nolink;     // item never links (find or label out of range)
    logic is_root;    // parent of current label is itself
    logic same_root;  // second root equals first
    logic clr_last;   // init sweep at last entry
  } sts_t;

endpackage

@@ src/wcuf_ram.sv @@
// ----------------------------------------------------------------------------
// wcuf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wcuf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/wcuf_datapath.sv @@
// ----------------------------------------------------------------------------
// wcuf_datapath
// Parent store, walk registers, link write and result registers.
// ----------------------------------------------------------------------------
module wcuf_datapath
  import wcuf_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  output sts_t   sts,
  input  logic   in_operation,
  input  label_t in_node_a,
  input  label_t in_node_b,
  output label_t root,
  output logic   merged
);

  localparam int AW = $clog2(NODES);

  label_t          b_q;
  label_t          cur;
  label_t          ra;
  label_t          pend_root;
  logic            pend_merged;
  logic            nolink;
  logic [AW-1:0]   clr_idx;

  label_t          up;
  label_t          lo;
  label_t          hi;
  logic            up_oor;
  logic            in_b_oor;
  logic            we;
  logic [AW-1:0]   waddr;
  label_t          wdata;
  logic [AW-1:0]   raddr;

  assign sts.in_a_oor  = 32'(in_node_a) >= 32'(NODES);
  assign in_b_oor      = 32'(in_node_b) >= 32'(NODES);
  assign up_oor        = 32'(up) >= 32'(NODES);
  assign sts.nolink    = nolink;
  assign sts.is_root   = (up == cur) || up_oor;
  assign sts.same_root = (ra == cur);
  assign sts.clr_last  = (clr_idx == AW'(NODES - 1));

  assign lo = (ra < cur) ? ra : cur;
  assign hi = (ra < cur) ? cur : ra;

  // read address: first label of a walk, or the link just read
  always_comb begin
    if (cmd.load) begin
      raddr = AW'(in_node_a);
    end else if (cmd.start_b) begin
      raddr = AW'(b_q);
    end else begin
      raddr = AW'(up);
    end
  end

  always_comb begin
    we    = cmd.clear_we | cmd.link_we;
    waddr = cmd.clear_we ? clr_idx : AW'(hi);
    wdata = cmd.clear_we ? LABEL_W'(clr_idx) : lo;
  end

  wcuf_ram #(
    .WIDTH (LABEL_W),
    .DEPTH (NODES)
  ) u_parent (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (up)
  );

  // init sweep index starts from entry zero after every reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_we) begin
      clr_idx <= sts.clr_last ? '0 : clr_idx + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_q    <= in_node_b;
      cur    <= in_node_a;
      nolink <= (in_operation == OP_FIND) || sts.in_a_oor || in_b_oor;
    end else if (cmd.start_b) begin
      cur <= b_q;
    end else if (cmd.step) begin
      cur <= up;
    end
    if (cmd.start_b) begin
      ra <= cur;
    end
    if (cmd.pend_set) begin
      case (cmd.pend_sel)
        PEND_A: begin
          pend_root   <= in_node_a;
          pend_merged <= 1'b0;
        end
        PEND_MERGE: begin
          pend_root   <= lo;
          pend_merged <= 1'b1;
        end
        default: begin
          pend_root   <= cur;
          pend_merged <= 1'b0;
        end
      endcase
    end
    if (cmd.out_load) begin
      root   <= pend_root;
      merged <= pend_merged;
    end
  end

endmodule

@@ src/wcuf_ctrl.sv @@
// ----------------------------------------------------------------------------
// wcuf_ctrl
// Sequencer: init sweep, the two root walks, link and result handoff.
// ----------------------------------------------------------------------------
module wcuf_ctrl
  import wcuf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK_A = 3'd2;
  localparam logic [2:0] ST_WALK_B = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load = 1'b1;
          if (sts.in_a_oor) begin
            cmd.pend_set = 1'b1;
            cmd.pend_sel = PEND_A;
            state_next   = ST_RESULT;
          end else begin
            state_next = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        if (!sts.is_root) begin
          cmd.step = 1'b1;
        end else if (sts.nolink) begin
          cmd.pend_set = 1'b1;
          cmd.pend_sel = PEND_CUR;
          state_next   = ST_RESULT;
        end else begin
          cmd.start_b = 1'b1;
          state_next  = ST_WALK_B;
        end
      end
      ST_WALK_B: begin
        if (!sts.is_root) begin
          cmd.step = 1'b1;
        end else begin
          cmd.pend_set = 1'b1;
          state_next   = ST_RESULT;
          if (sts.same_root) begin
            cmd.pend_sel = PEND_CUR;
          end else begin
            cmd.pend_sel = PEND_MERGE;
            cmd.link_we  = 1'b1;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid || m_axis_tready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_link_at_root: assert property (@(posedge clk) disable iff (rst)
    cmd.link_we |-> (state == ST_WALK_B) && sts.is_root && !sts.same_root)
    else $error("link written outside second walk end");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_axis_tready && !out_valid)
    else $error("activity during init sweep");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_axis_tready))
    else $error("result overwritten before taken");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid && (state == ST_IDLE))
    else $error("result not presented after load");

endmodule

@@ src/weak_component_union_find.sv @@
// A find walks the parent links from node_a up to its root; a union with both
// labels in range walks from node_a and then from node_b to their roots.
// One item at a time; the next item is accepted the cycle after the result is
// registered, while that result may still wait on m_axis_tready.
// After rst the parent store is initialized by a sweep over all NODES entries,
// during which s_axis_tready stays low.
// ----------------------------------------------------------------------------
// weak_component_union_find
// Union-find engine for connected components, no path compression, links
// always point at the smaller root.
// ----------------------------------------------------------------------------
module weak_component_union_find
  import wcuf_pkg::*;
#(
  parameter int NODES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] node_a, [19:10] node_b, [23:20] zero
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [9:0] root, [15:10] zero
  output logic        m_axis_tuser    // [0] merged
);

  cmd_t   cmd;
  sts_t   sts;
  label_t root;

  wcuf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  wcuf_datapath #(
    .NODES (NODES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_operation (s_axis_tuser),
    .in_node_a    (s_axis_tdata[9:0]),
    .in_node_b    (s_axis_tdata[19:10]),
    .root         (root),
    .merged       (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, root};

endmodule
